@@ rtl/iss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iss_pkg: shared types and codes of the indexed sequence store
// Command and status codes, field widths and the cell operation codes.
// ----------------------------------------------------------------------------
package iss_pkg;

	localparam int CMD_W = 4;
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int CNT_W = 7;

	typedef logic [CMD_W-1:0]        cmd_t;
	typedef logic [POS_W-1:0]        pos_t;
	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [ST_W-1:0]         status_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	localparam cmd_t CMD_PUSH_FRONT = 4'd0;
	localparam cmd_t CMD_PUSH_BACK  = 4'd1;
	localparam cmd_t CMD_POP_FRONT  = 4'd2;
	localparam cmd_t CMD_POP_BACK   = 4'd3;
	localparam cmd_t CMD_READ_AT    = 4'd4;
	localparam cmd_t CMD_READ_END   = 4'd5;
	localparam cmd_t CMD_INSERT     = 4'd6;
	localparam cmd_t CMD_ERASE      = 4'd7;
	localparam cmd_t CMD_REMOVE     = 4'd8;

	localparam status_t ST_OK      = 2'd0;
	localparam status_t ST_RANGE   = 2'd1;
	localparam status_t ST_FULL    = 2'd2;
	localparam status_t ST_MISSING = 2'd3;

	typedef logic [1:0] cell_op_t;

	localparam cell_op_t CELL_HOLD      = 2'd0;
	localparam cell_op_t CELL_TAKE_PREV = 2'd1;
	localparam cell_op_t CELL_TAKE_NEXT = 2'd2;
	localparam cell_op_t CELL_LOAD      = 2'd3;

endpackage
`default_nettype wire

@@ rtl/iss_cmd_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iss_cmd_if: command channel of the indexed sequence store
// Valid/ready channel that carries one command per transfer.
// ----------------------------------------------------------------------------
interface iss_cmd_if;
	import iss_pkg::*;

	logic valid;
	logic ready;
	cmd_t cmd;
	pos_t position;
	val_t item_value;

	modport source (output valid, output cmd, output position, output item_value,
		input ready);
	modport sink (input valid, input cmd, input position, input item_value,
		output ready);

endinterface
`default_nettype wire

@@ rtl/iss_res_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iss_res_if: result channel of the indexed sequence store
// Valid/ready channel that carries one result per transfer.
// ----------------------------------------------------------------------------
interface iss_res_if;
	import iss_pkg::*;

	logic    valid;
	logic    ready;
	val_t    read_value;
	status_t status;
	cnt_t    count_now;
	logic    is_empty;

	modport source (output valid, output read_value, output status, output count_now,
		output is_empty, input ready);
	modport sink (input valid, input read_value, input status, input count_now,
		input is_empty, output ready);

endinterface
`default_nettype wire

@@ rtl/indexed_sequence_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_sequence_store: bounded ordered sequence with indexed access
// A command is taken only while idle, and not again until its result commits:
// the compare across the cell row is registered on acceptance, then, once the
// result channel is free, every cell takes from a neighbor, loads, or holds.
// Reset clears the count and the handshake; cell values are undefined until
// written and are never read beyond the count.
// ----------------------------------------------------------------------------
module indexed_sequence_store #(
	parameter int DEPTH = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	iss_cmd_if.sink   req,
	iss_res_if.source rsp
);
	import iss_pkg::*;

	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;

	logic [CW-1:0]    count_q;
	cmd_t             cmd_s1;
	pos_t             pos_s1;
	val_t             val_s1;
	logic [DEPTH-1:0] match_s1;

	logic    rsp_valid_q;
	val_t    rv_q;
	status_t st_q;
	cnt_t    cnt_out_q;
	logic    empty_q;

	val_t     cell_value [DEPTH];
	logic     cell_equal [DEPTH];
	cell_op_t cell_op    [DEPTH];
	logic [DEPTH-1:0] match_d;
	logic [DEPTH-1:0] seen;
	logic [DEPTH-1:0] sel_eq;

	logic accept;
	logic commit;

	logic            do_open;
	logic            do_close;
	logic            do_read;
	logic            use_match;
	logic [CMPW-1:0] target;
	status_t         status_d;
	val_t            rd_value;
	logic [CW-1:0]   count_d;

	logic [CMPW-1:0] cnt_x;
	logic [CMPW-1:0] pos_x;
	logic            full;

	assign accept = req.valid && req.ready;
	assign commit = (state_q == S_EXEC) && (!rsp_valid_q || rsp.ready);
	assign req.ready = (state_q == S_IDLE);

	assign cnt_x = CMPW'(count_q);
	assign pos_x = CMPW'(pos_s1);
	assign full  = (count_q == CW'(DEPTH));

	always_comb begin
		do_open   = 1'b0;
		do_close  = 1'b0;
		do_read   = 1'b0;
		use_match = 1'b0;
		target    = '0;
		status_d  = ST_OK;
		unique case (cmd_s1)
			CMD_PUSH_FRONT: begin
				if (full) status_d = ST_FULL;
				else do_open = 1'b1;
			end
			CMD_PUSH_BACK: begin
				target = cnt_x;
				if (full) status_d = ST_FULL;
				else do_open = 1'b1;
			end
			CMD_POP_FRONT: begin
				if (count_q == '0) status_d = ST_RANGE;
				else do_close = 1'b1;
			end
			CMD_POP_BACK: begin
				target = cnt_x - CMPW'(1);
				if (count_q == '0) status_d = ST_RANGE;
				else do_close = 1'b1;
			end
			CMD_READ_AT: begin
				target = pos_x;
				if (pos_x >= cnt_x) status_d = ST_RANGE;
				else do_read = 1'b1;
			end
			CMD_READ_END: begin
				target = cnt_x - pos_x;
				if (pos_x == '0 || pos_x > cnt_x) status_d = ST_RANGE;
				else do_read = 1'b1;
			end
			CMD_INSERT: begin
				target = pos_x;
				if (full) status_d = ST_FULL;
				else if (pos_x > cnt_x) status_d = ST_RANGE;
				else do_open = 1'b1;
			end
			CMD_ERASE: begin
				target = pos_x;
				if (pos_x >= cnt_x) status_d = ST_RANGE;
				else do_close = 1'b1;
			end
			CMD_REMOVE: begin
				use_match = 1'b1;
				if (|match_s1) do_close = 1'b1;
				else status_d = ST_MISSING;
			end
			default: status_d = ST_RANGE;
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic sel_ge;

			if (gi == 0) begin : g_first
				assign seen[gi] = 1'b0;
			end else begin : g_rest
				assign seen[gi] = |match_s1[gi-1:0];
			end

			assign match_d[gi] = cell_equal[gi] && (CMPW'(gi) < cnt_x);

			always_comb begin
				if (use_match) begin
					sel_eq[gi] = match_s1[gi] && !seen[gi];
					sel_ge     = match_s1[gi] || seen[gi];
				end else begin
					sel_eq[gi] = (CMPW'(gi) == target);
					sel_ge     = (CMPW'(gi) >= target);
				end
				cell_op[gi] = CELL_HOLD;
				if (commit && do_open) begin
					if (sel_eq[gi]) cell_op[gi] = CELL_LOAD;
					else if (sel_ge) cell_op[gi] = CELL_TAKE_PREV;
				end else if (commit && do_close && sel_ge) begin
					cell_op[gi] = CELL_TAKE_NEXT;
				end
			end

			iss_cell u_cell (
				.clk        (clk),
				.op         (cell_op[gi]),
				.prev_value (cell_value[(gi == 0) ? 0 : gi - 1]),
				.next_value (cell_value[(gi == DEPTH - 1) ? gi : gi + 1]),
				.load_value (val_s1),
				.cmp_value  (req.item_value),
				.value      (cell_value[gi]),
				.equal      (cell_equal[gi])
			);
		end
	endgenerate

	always_comb begin
		rd_value = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (sel_eq[i]) rd_value = rd_value | cell_value[i];
		end
		if (!(do_read || do_close)) rd_value = '0;
	end

	always_comb begin
		count_d = count_q;
		if (do_open) count_d = count_q + CW'(1);
		else if (do_close) count_d = count_q - CW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (commit) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= req.cmd;
			pos_s1   <= req.position;
			val_s1   <= req.item_value;
			match_s1 <= match_d;
		end
		if (commit) begin
			rv_q      <= rd_value;
			st_q      <= status_d;
			cnt_out_q <= CNT_W'(count_d);
			empty_q   <= (count_d == '0);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = rv_q;
	assign rsp.status     = st_q;
	assign rsp.count_now  = cnt_out_q;
	assign rsp.is_empty   = empty_q;

endmodule
`default_nettype wire

@@ rtl/iss_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// iss_cell: one storage cell of the sequence row
// Holds one value, shifts from either neighbor or loads a new value, and
// compares its value against a search key.
// ----------------------------------------------------------------------------
module iss_cell (
	input  wire logic            clk,
	input  wire iss_pkg::cell_op_t op,
	input  wire iss_pkg::val_t   prev_value,
	input  wire iss_pkg::val_t   next_value,
	input  wire iss_pkg::val_t   load_value,
	input  wire iss_pkg::val_t   cmp_value,
	output iss_pkg::val_t        value,
	output logic                 equal
);
	import iss_pkg::*;

	val_t value_q;

	always_ff @(posedge clk) begin
		unique case (op)
			CELL_HOLD:      value_q <= value_q;
			CELL_TAKE_PREV: value_q <= prev_value;
			CELL_TAKE_NEXT: value_q <= next_value;
			CELL_LOAD:      value_q <= load_value;
			default:        value_q <= value_q;
		endcase
	end

	assign value = value_q;
	assign equal = (value_q == cmp_value);

endmodule
`default_nettype wire
